>>> src/sorted_key_table_macros.svh
// Assertion macros used by the sorted key table datapath.
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SKT_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/skt_pkg.sv
// Types and constants shared by the sorted key table modules.
`default_nettype none

package skt_pkg;

   localparam int KEY_W     = 32;
   localparam int PAY_W     = 32;
   localparam int STATUS_W  = 2;
   localparam int POS_W     = 4;
   localparam int FILL_W    = 5;

   // Operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic                    operation;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        payload;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [FILL_W-1:0]   fill_count;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic update;
   } skt_cmd_type;

endpackage

`default_nettype wire

>>> src/skt_ctrl.sv
// Controller: sequences compare and update for each transaction.
`default_nettype none

module skt_ctrl
   import skt_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  start,
   output logic       busy,
   output skt_cmd_type cmd,
   output logic       rsp_valid
);

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd.capture  = 1'b0;
      cmd.update   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> src/skt_datapath.sv
// Datapath: entry cells, parallel compare, shift update and result register.
`default_nettype none

`include "sorted_key_table_macros.svh"

module skt_datapath
   import skt_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire skt_cmd_type cmd,
   input  wire req_type req_data,
   output rsp_type      rsp_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Entry cells; contents above the fill count are don't-care
   logic signed [KEY_W-1:0] key_ff [DEPTH];
   logic [PAY_W-1:0]        pay_ff [DEPTH];
   logic [CNT_W-1:0]        cnt_ff;
   logic [CNT_W-1:0]        cnt_in;

   // Captured transaction and compare vectors
   req_type          req_ff;
   logic [DEPTH-1:0] less_ff;
   logic [DEPTH-1:0] eq_ff;
   logic [DEPTH-1:0] less_in;
   logic [DEPTH-1:0] eq_in;

   rsp_type rsp_ff;
   rsp_type rsp_in;

   // Insert/delete point: first entry whose key is not smaller
   logic [DEPTH-1:0] edge_vec;
   logic [IDX_W-1:0] pos;
   logic             found;
   logic             full;
   logic             ins_ok;
   logic             del_ok;

   // Neighbor values for the shifts
   logic signed [KEY_W-1:0] prev_key [DEPTH];
   logic [PAY_W-1:0]        prev_pay [DEPTH];
   logic signed [KEY_W-1:0] next_key [DEPTH];
   logic [PAY_W-1:0]        next_pay [DEPTH];

   // Parallel compare of the incoming key against every valid entry
   for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
      logic valid;
      assign valid      = (CNT_W'(i) < cnt_ff);
      assign less_in[i] = valid && (key_ff[i] < req_data.key);
      assign eq_in[i]   = valid && (key_ff[i] == req_data.key);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff  <= req_data;
         less_ff <= less_in;
         eq_ff   <= eq_in;
      end
   end

   // One-hot edge of the thermometer less vector
   for (genvar i = 0; i < DEPTH; i++) begin : g_edge
      if (i == 0) begin : g_first
         assign edge_vec[i] = !less_ff[i];
      end else begin : g_rest
         assign edge_vec[i] = !less_ff[i] && less_ff[i-1];
      end
   end

   always_comb begin
      pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (edge_vec[i]) begin
            pos = pos | IDX_W'(i);
         end
      end
   end

   assign found  = |(edge_vec & eq_ff);
   assign full   = (cnt_ff == CNT_W'(DEPTH));
   assign ins_ok = (req_ff.operation == OP_INSERT) && !full;
   assign del_ok = (req_ff.operation == OP_DELETE) && found;

   // Neighbor taps
   for (genvar i = 0; i < DEPTH; i++) begin : g_nbr
      if (i == 0) begin : g_lo
         assign prev_key[i] = key_ff[i];
         assign prev_pay[i] = pay_ff[i];
      end else begin : g_lo_n
         assign prev_key[i] = key_ff[i-1];
         assign prev_pay[i] = pay_ff[i-1];
      end
      if (i == DEPTH - 1) begin : g_hi
         assign next_key[i] = key_ff[i];
         assign next_pay[i] = pay_ff[i];
      end else begin : g_hi_n
         assign next_key[i] = key_ff[i+1];
         assign next_pay[i] = pay_ff[i+1];
      end
   end

   // Cell update: open a slot on insert, close the gap on delete
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      always_ff @(posedge clock) begin
         if (cmd.update && ins_ok && !less_ff[i]) begin
            if (edge_vec[i]) begin
               key_ff[i] <= req_ff.key;
               pay_ff[i] <= req_ff.payload;
            end else begin
               key_ff[i] <= prev_key[i];
               pay_ff[i] <= prev_pay[i];
            end
         end else if (cmd.update && del_ok && !less_ff[i]) begin
            key_ff[i] <= next_key[i];
            pay_ff[i] <= next_pay[i];
         end
      end
   end

   // Fill count
   always_comb begin
      cnt_in = cnt_ff;
      if (ins_ok) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (del_ok) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.update) begin
         cnt_ff <= cnt_in;
      end
   end

   // Result fields
   always_comb begin
      rsp_in.fill_count = FILL_W'(cnt_in);
      rsp_in.position   = '0;
      if (req_ff.operation == OP_INSERT) begin
         rsp_in.status = full ? ST_FULL : ST_INSERTED;
         if (ins_ok) begin
            rsp_in.position = POS_W'(pos);
         end
      end else begin
         rsp_in.status = found ? ST_DELETED : ST_NOT_FOUND;
         if (del_ok) begin
            rsp_in.position = POS_W'(pos);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // Checks
   `SKT_ASSERT(a_less_thermo, clock, reset, cmd.update, ((less_ff >> 1) & ~less_ff) == '0, "compare vector is not a thermometer code; entries out of order")
   `SKT_ASSERT_NEXT(a_ins_count, clock, reset, cmd.update && ins_ok, cnt_ff == $past(cnt_ff) + CNT_W'(1), "insert did not raise the fill count by one")
   `SKT_ASSERT_NEXT(a_del_count, clock, reset, cmd.update && del_ok, cnt_ff == $past(cnt_ff) - CNT_W'(1), "delete did not lower the fill count by one")
   `SKT_ASSERT_NEXT(a_count_hold, clock, reset, !cmd.update, $stable(cnt_ff), "fill count changed outside an update")

endmodule

`default_nettype wire

>>> src/sorted_key_table.sv
// Sorted key table: ascending table of signed keys with payload handles.
//
// In the cycle start is accepted the new key is compared against every
// stored entry at once, and in the next cycle the entries shift by one
// place around the insert or delete point and the result is registered.
// busy is high during the update only, and no new start is taken while
// busy is high. The result appears on rsp_data with rsp_valid high for
// exactly one cycle, the cycle right after the update, which is also a
// cycle in which the next start can be taken. The receiver cannot stall
// results: it must take each one in the cycle it is shown. Inserts into a
// full table return the full status and leave the table alone; a delete of
// a missing key returns not-found. Entry storage needs no clearing after
// reset, only the fill count resets.
`default_nettype none

module sorted_key_table
   import skt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   skt_cmd_type cmd;

   // Sequencing
   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   // Storage, compare and shift
   skt_datapath #(
      .DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the sorted key table: insert/delete traffic against a table model.
`default_nettype none

module tb;
   import skt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH  = 16;
   localparam int RANDOM_OPS   = 1000;
   localparam int SETTLE_CYCS  = 8;
   localparam int SETTLE_LIMIT = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Pending transactions and expected results
   req_type op_queue[$];
   rsp_type expected_rsp[$];

   // Table model state
   logic signed [KEY_W-1:0] tbl_key[TABLE_DEPTH];
   logic [PAY_W-1:0]        tbl_pay[TABLE_DEPTH];
   int                      fill = 0;

   int total_ops = 0;
   int ops_sent  = 0;
   int err_count = 0;
   int n_inserted = 0;
   int n_full     = 0;
   int n_deleted  = 0;
   int n_missing  = 0;
   int peak_fill  = 0;

   // Keys handed out by inserts, so deletes mostly hit
   logic signed [KEY_W-1:0] issued_keys[$];

   sorted_key_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always #4 clock = ~clock;

   // Apply one operation to the table model and return its result
   function automatic rsp_type apply_op(req_type rq);
      rsp_type r;
      int      pos;
      int      i;
      r   = '0;
      pos = 0;
      if (rq.operation == OP_INSERT) begin
         if (fill >= TABLE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            while (pos < fill && tbl_key[pos] < rq.key) pos++;
            for (i = fill; i > pos; i--) begin
               tbl_key[i] = tbl_key[i-1];
               tbl_pay[i] = tbl_pay[i-1];
            end
            tbl_key[pos] = rq.key;
            tbl_pay[pos] = rq.payload;
            fill++;
            r.status   = ST_INSERTED;
            r.position = pos[POS_W-1:0];
         end
      end else begin
         while (pos < fill && tbl_key[pos] != rq.key) pos++;
         if (pos >= fill) begin
            r.status = ST_NOT_FOUND;
         end else begin
            for (i = pos; i + 1 < fill; i++) begin
               tbl_key[i] = tbl_key[i+1];
               tbl_pay[i] = tbl_pay[i+1];
            end
            fill--;
            r.status   = ST_DELETED;
            r.position = pos[POS_W-1:0];
         end
      end
      r.fill_count = fill[FILL_W-1:0];
      if (fill > peak_fill) peak_fill = fill;
      return r;
   endfunction

   task automatic queue_op(logic op, logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] p);
      req_type rq;
      rq.operation = op;
      rq.key       = k;
      rq.payload   = p;
      op_queue.push_back(rq);
   endtask

   // Mix of small clustered keys (many duplicates), extremes and fully random words
   function automatic logic signed [KEY_W-1:0] pick_key();
      logic signed [KEY_W-1:0] k;
      case ($urandom_range(3))
         0, 1: k = int'($urandom_range(8)) - 4;
         2: begin
            case ($urandom_range(4))
               0: k = 32'sh8000_0000;
               1: k = 32'sh7fff_ffff;
               2: k = 32'sh8000_0001;
               3: k = 32'sh7fff_fffe;
               default: k = -1;
            endcase
         end
         default: k = $urandom;
      endcase
      return k;
   endfunction

   // Stimulus: directed corner cases, then random insert/delete bursts
   initial begin
      int                      blk;
      int                      n;
      int                      idx;
      logic signed [KEY_W-1:0] k;
      logic                    op;

      // delete from an empty table
      queue_op(OP_DELETE, 32'sd5, 32'hffff_ffff);
      queue_op(OP_INSERT, 32'sh8000_0000, 32'h0000_0000);
      queue_op(OP_INSERT, 32'sh7fff_ffff, 32'hffff_ffff);
      queue_op(OP_INSERT, 32'sd0, 32'h5555_5555);
      queue_op(OP_INSERT, -32'sd1, 32'haaaa_aaaa);
      // equal key goes ahead of the stored one, delete takes the first match
      queue_op(OP_INSERT, 32'sd0, 32'h1234_5678);
      queue_op(OP_DELETE, 32'sd0, 32'h0000_0000);
      queue_op(OP_DELETE, 32'sd0, 32'hffff_ffff);
      queue_op(OP_INSERT, 32'sd0, 32'h0f0f_0f0f);
      // fill the table to capacity, then one refused insert
      for (n = 0; n < 12; n++) queue_op(OP_INSERT, n * 1000 - 6000, $urandom);
      queue_op(OP_INSERT, 32'sd7, 32'hdead_beef);
      queue_op(OP_DELETE, 32'sh7fff_ffff, 32'h0);
      queue_op(OP_DELETE, 32'sh8000_0000, 32'h0);
      queue_op(OP_DELETE, 32'sd42, 32'h0);

      // alternate insert-heavy and delete-heavy bursts to sweep empty to full
      blk = 0;
      n   = 0;
      while (n < RANDOM_OPS) begin
         repeat (40) begin
            if (blk % 2 == 0) op = ($urandom_range(99) < 75) ? OP_INSERT : OP_DELETE;
            else              op = ($urandom_range(99) < 75) ? OP_DELETE : OP_INSERT;
            if (op == OP_INSERT) begin
               k = pick_key();
               issued_keys.push_back(k);
            end else if (issued_keys.size() != 0 && $urandom_range(99) < 70) begin
               idx = $urandom_range(issued_keys.size() - 1);
               k   = issued_keys[idx];
               issued_keys.delete(idx);
            end else begin
               k = pick_key();
            end
            queue_op(op, k, $urandom);
            n++;
         end
         blk++;
      end
      total_ops = op_queue.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: present queued transactions, hold while busy, insert random gaps
   always @(posedge clock) begin
      int idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) begin
            expected_rsp.push_back(apply_op(req_data));
            ops_sent++;
         end
         if (ops_sent < total_ops / 3)          idle_pct = 12;
         else if (ops_sent < 2 * total_ops / 3) idle_pct = 75;
         else                                   idle_pct = 0;
         if (op_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start    <= 1'b1;
            req_data <= op_queue.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check each result strobe against the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result: status %0d position %0d fill_count %0d",
                   rsp_data.status, rsp_data.position, rsp_data.fill_count);
            err_count++;
         end else begin
            exp_r = expected_rsp.pop_front();
            case (exp_r.status)
               ST_INSERTED: n_inserted++;
               ST_FULL:     n_full++;
               ST_DELETED:  n_deleted++;
               default:     n_missing++;
            endcase
            if (rsp_data.status !== exp_r.status) begin
               $error("status: expected %0d, actual %0d", exp_r.status, rsp_data.status);
               err_count++;
            end
            if (rsp_data.position !== exp_r.position) begin
               $error("position: expected %0d, actual %0d",
                      exp_r.position, rsp_data.position);
               err_count++;
            end
            if (rsp_data.fill_count !== exp_r.fill_count) begin
               $error("fill_count: expected %0d, actual %0d",
                      exp_r.fill_count, rsp_data.fill_count);
               err_count++;
            end
         end
      end
   end

   // End of test: drain, settle, report
   initial begin
      int waited;
      waited = 0;
      @(negedge reset);
      while (ops_sent < total_ops || total_ops == 0) @(posedge clock);
      while (expected_rsp.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCS) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d results never arrived", expected_rsp.size());
         err_count++;
      end
      $display("tb: %0d transactions: %0d inserted, %0d refused full, %0d deleted, %0d missed",
               ops_sent, n_inserted, n_full, n_deleted, n_missing);
      $display("tb: peak fill %0d of %0d, %0d mismatches", peak_fill, TABLE_DEPTH, err_count);
      if (err_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2ms;
      $display("tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
